// ===== rtl/core/mvat_pkg.sv =====
// ----------------------------------------------------------------------------
// mvat_pkg
// Shared types and constants of the MIDI voice allocator / timer setup block.
// ----------------------------------------------------------------------------
package mvat_pkg;

	localparam int VOICES = 4;

	// request kinds on the input tuser field
	localparam logic [1:0] REQ_MIDI   = 2'd0;
	localparam logic [1:0] REQ_TBL    = 2'd1;
	localparam logic [1:0] REQ_ALLOFF = 2'd2;

	// status byte upper nibbles
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_BEND     = 4'hE;

	localparam logic [13:0] BEND_CENTER = 14'd8192;
	localparam logic [15:0] LN2_Q16     = 16'd45426;
	// x / 49152 = ((x >> 14) * ceil(2^17 / 3)) >> 17, exact for x >> 14 below 2^17
	localparam logic [15:0] DIV3_RECIP  = 16'd43691;
	localparam logic [16:0] ONE_Q16     = 17'd65536;

	typedef enum logic [2:0] {
		K_NONE,
		K_TBL,
		K_ALLOFF,
		K_ON,
		K_OFF,
		K_BEND
	} kind_t;

	typedef struct packed {
		logic load_item;
		logic tbl_wr;
		logic tbl_rd;
		logic on_set;
		logic off_set;
		logic alloff_set;
		logic alloff_next;
		logic tdiv_start;
		logic t_load;
		logic fac_load;
		logic first_busy;
		logic next_busy;
		logic bend_mul;
		logic bend_sat;
		logic prog_setup;
		logic rel_start;
		logic res_zero;
		logic res_rel;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  on_ok;
		logic  off_ok;
		logic  bend_ok;
		logic  is_last;
		logic  zero;
		logic  div_done;
		logic  out_full;
	} stat_t;

	// prescaler exponent: prescaler = 2^k - 1
	function automatic logic [3:0] band_shift(input logic [15:0] f);
		logic [3:0] k;
		if (f == 16'd1) k = 4'd10;
		else if (f <= 16'd3) k = 4'd9;
		else if (f <= 16'd7) k = 4'd8;
		else if (f <= 16'd15) k = 4'd7;
		else if (f <= 16'd32) k = 4'd6;
		else if (f <= 16'd63) k = 4'd5;
		else if (f <= 16'd127) k = 4'd4;
		else if (f <= 16'd255) k = 4'd3;
		else if (f <= 16'd511) k = 4'd2;
		else k = 4'd1;
		return k;
	endfunction

	// max(5, 16/f) for f >= 1
	function automatic logic [9:0] min_pw(input logic [15:0] f);
		logic [9:0] m;
		if (f == 16'd1) m = 10'd16;
		else if (f == 16'd2) m = 10'd8;
		else m = 10'd5;
		return m;
	endfunction

endpackage

// ===== rtl/core/mvat_div.sv =====
// ----------------------------------------------------------------------------
// mvat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mvat_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] rem_sh, diff;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/core/mvat_dp.sv =====
// ----------------------------------------------------------------------------
// mvat_dp
// Datapath: configuration registers, item register, voice state, frequency
// table, bend math, timer value computation and the result register.
// ----------------------------------------------------------------------------
module mvat_dp #(
	parameter int TIMER_CLOCK_HZ = 64000000,
	parameter int NOTE_ENTRIES   = 96
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mvat_pkg::cmd_t  cmd,
	output mvat_pkg::stat_t stat,
	input  logic [1:0]      req_type,
	input  logic [7:0]      status,
	input  logic [6:0]      data1,
	input  logic [6:0]      data2,
	input  logic [6:0]      table_index,
	input  logic [15:0]     table_freq,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      voice,
	output logic            enable,
	output logic [9:0]      prescaler,
	output logic [15:0]     reload,
	output logic [15:0]     compare,
	output logic            last
);
	import mvat_pkg::*;

	localparam int TBL_AW = (NOTE_ENTRIES > 1) ? $clog2(NOTE_ENTRIES) : 1;
	localparam logic [31:0] TCLK = 32'(TIMER_CLOCK_HZ);

	// configuration
	logic [15:0] max_freq_q;
	logic [9:0]  max_pw_q, pw_a_q, pw_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_freq_q <= 16'd1000;
			max_pw_q   <= 10'd200;
			pw_a_q     <= 10'd100;
			pw_b_q     <= 10'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				2'd0:    max_freq_q <= cfg_data;
				2'd1:    max_pw_q   <= cfg_data[9:0];
				2'd2:    pw_a_q     <= cfg_data[9:0];
				2'd3:    pw_b_q     <= cfg_data[9:0];
				default: max_freq_q <= max_freq_q;
			endcase
		end
	end

	// item register
	kind_t       kind_q;
	logic [6:0]  d1_q, d2_q, tidx_q;
	logic [15:0] tfreq_q;
	kind_t       kind_d;

	always_comb begin
		kind_d = K_NONE;
		case (req_type)
			REQ_TBL:    kind_d = K_TBL;
			REQ_ALLOFF: kind_d = K_ALLOFF;
			REQ_MIDI: begin
				if (status[7:4] == MSG_NOTE_ON) kind_d = K_ON;
				else if (status[7:4] == MSG_NOTE_OFF) kind_d = K_OFF;
				else if (status[7:4] == MSG_BEND) kind_d = K_BEND;
				else kind_d = K_NONE;
			end
			default: kind_d = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) kind_q <= K_NONE;
		else if (cmd.load_item) kind_q <= kind_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			d1_q    <= data1;
			d2_q    <= data2;
			tidx_q  <= table_index;
			tfreq_q <= table_freq;
		end
	end

	// frequency table
	logic [15:0] tbl_mem [NOTE_ENTRIES];
	logic [15:0] tbl_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && (32'(tidx_q) < 32'(NOTE_ENTRIES)))
			tbl_mem[tidx_q[TBL_AW-1:0]] <= tfreq_q;
		if (cmd.tbl_rd)
			tbl_rd_q <= tbl_mem[d1_q[TBL_AW-1:0]];
	end

	// voice state
	logic [VOICES-1:0] busy_q;
	logic [6:0]        note_q [VOICES];
	logic [15:0]       base_q [VOICES];
	logic [1:0]        ptr_q;

	logic       free_found, match_found, nxt_found, first_found;
	logic [1:0] free_idx, match_idx, nxt_idx, first_idx;

	always_comb begin
		free_found = 1'b0; free_idx = '0;
		match_found = 1'b0; match_idx = '0;
		nxt_found = 1'b0; nxt_idx = '0;
		first_found = 1'b0; first_idx = '0;
		for (int v = VOICES - 1; v >= 0; v--) begin
			if (!busy_q[v]) begin
				free_found = 1'b1; free_idx = 2'(v);
			end
			if (busy_q[v] && note_q[v] == d1_q) begin
				match_found = 1'b1; match_idx = 2'(v);
			end
			if (busy_q[v]) begin
				first_found = 1'b1; first_idx = 2'(v);
			end
			if (busy_q[v] && 2'(v) > ptr_q) begin
				nxt_found = 1'b1; nxt_idx = 2'(v);
			end
		end
	end

	logic [15:0] freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			ptr_q  <= '0;
			for (int v = 0; v < VOICES; v++) begin
				note_q[v] <= '0;
				base_q[v] <= '0;
			end
		end else begin
			if (cmd.tbl_rd) ptr_q <= free_idx;
			if (cmd.on_set) begin
				busy_q[ptr_q] <= 1'b1;
				note_q[ptr_q] <= d1_q;
				base_q[ptr_q] <= tbl_rd_q;
			end
			if (cmd.off_set) begin
				ptr_q <= match_idx;
				busy_q[match_idx] <= 1'b0;
			end
			if (cmd.alloff_set) begin
				ptr_q  <= '0;
				busy_q <= '0;
			end
			if (cmd.alloff_next) ptr_q <= ptr_q + 2'd1;
			if (cmd.first_busy) ptr_q <= first_idx;
			if (cmd.next_busy) ptr_q <= nxt_idx;
		end
	end

	// bend math
	logic [13:0] bv, mag;
	logic        bneg;
	logic [29:0] tprod;
	logic [29:0] tprod_s1;
	logic [15:0] tsh;
	logic [31:0] trec;
	logic [12:0] q_q;
	logic        neg_q;
	logic [25:0] qsq;
	logic [17:0] fac_sum;
	logic [16:0] fac_q;
	logic [32:0] bprod_s1;
	logic [16:0] bf;

	assign bv    = {d2_q, d1_q};
	assign bneg  = (bv < BEND_CENTER);
	assign mag   = bneg ? (BEND_CENTER - bv) : (bv - BEND_CENTER);
	assign tprod = 30'(mag) * 30'(LN2_Q16);
	// |t| = tprod / 49152 by shift and reciprocal multiply
	assign tsh   = tprod_s1[29:14];
	assign trec  = 32'(tsh) * 32'(DIV3_RECIP);
	assign qsq   = 26'(q_q) * 26'(q_q);
	assign fac_sum = neg_q ? (18'(ONE_Q16) - 18'(q_q) + 18'(qsq[25:17]))
	                       : (18'(ONE_Q16) + 18'(q_q) + 18'(qsq[25:17]));
	assign bf    = bprod_s1[32:16];

	// reload divider
	logic        div_start, div_done;
	logic [31:0] div_num, div_den, div_quo;

	// program setup
	logic [15:0] maxf, fc;
	logic [9:0]  pw, pwc, mpw;
	logic [3:0]  k;
	logic [15:0] cmp_c;
	logic [15:0] fc_q, cmp_q;
	logic [3:0]  k_q;
	logic        zero_q;

	always_comb begin
		pw   = ptr_q[1] ? pw_b_q : pw_a_q;
		maxf = (max_freq_q == 16'd0) ? 16'd1 : max_freq_q;
		fc   = (freq_q > maxf) ? maxf : freq_q;
		mpw  = min_pw(fc);
		pwc  = (pw > max_pw_q) ? max_pw_q : pw;
		pwc  = (pwc < mpw) ? mpw : pwc;
		k    = band_shift(fc);
		cmp_c = {pwc, 6'd0} >> k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zero_q <= 1'b0;
		else if (cmd.prog_setup) zero_q <= (pw == 10'd0) || (freq_q == 16'd0);
	end

	always_ff @(posedge clk) begin
		if (cmd.tdiv_start) tprod_s1 <= tprod;
		if (cmd.t_load) begin
			q_q   <= trec[29:17];
			neg_q <= bneg;
		end
		if (cmd.fac_load) fac_q <= fac_sum[16:0];
		if (cmd.bend_mul) bprod_s1 <= 33'(base_q[ptr_q]) * 33'(fac_q);
		if (cmd.on_set) freq_q <= tbl_rd_q;
		else if (cmd.off_set || cmd.alloff_set || cmd.alloff_next) freq_q <= '0;
		else if (cmd.bend_sat) freq_q <= bf[16] ? 16'hFFFF : bf[15:0];
		if (cmd.prog_setup) begin
			fc_q  <= fc;
			k_q   <= k;
			cmp_q <= cmp_c;
		end
	end

	assign div_start = cmd.rel_start;
	assign div_num   = TCLK;
	assign div_den   = 32'(fc_q) << k_q;

	mvat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// result register
	logic        is_last;
	logic        ov_q;
	logic [10:0] psc_w;

	always_comb begin
		case (kind_q)
			K_ALLOFF: is_last = (ptr_q == 2'd3);
			K_BEND:   is_last = !nxt_found;
			default:  is_last = 1'b1;
		endcase
	end

	assign psc_w = (11'd1 << k_q) - 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.res_zero || cmd.res_rel) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			voice     <= ptr_q;
			enable    <= 1'b0;
			prescaler <= '0;
			reload    <= '0;
			compare   <= '0;
			last      <= is_last;
		end else if (cmd.res_rel) begin
			voice     <= ptr_q;
			enable    <= 1'b1;
			prescaler <= psc_w[9:0];
			reload    <= (div_quo > 32'd65535) ? 16'hFFFF : div_quo[15:0];
			compare   <= cmp_q;
			last      <= is_last;
		end
	end

	assign out_valid = ov_q;

	assign stat.kind     = kind_q;
	assign stat.on_ok    = free_found && (32'(d1_q) < 32'(NOTE_ENTRIES));
	assign stat.off_ok   = match_found;
	assign stat.bend_ok  = first_found;
	assign stat.is_last  = is_last;
	assign stat.zero     = zero_q;
	assign stat.div_done = div_done;
	assign stat.out_full = ov_q;
endmodule

// ===== rtl/core/mvat_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvat_ctrl
// Sequencer: decodes the item and steps the datapath through each result.
// ----------------------------------------------------------------------------
module mvat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mvat_pkg::stat_t stat,
	output mvat_pkg::cmd_t  cmd
);
	import mvat_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ON_READ,
		S_BEND_DIV,
		S_BEND_FAC,
		S_BEND_MUL,
		S_BEND_SAT,
		S_PROG,
		S_PROG2,
		S_REL_WAIT,
		S_OUT
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (stat.kind)
					K_TBL: cmd.tbl_wr = 1'b1;
					K_ALLOFF: begin
						cmd.alloff_set = 1'b1;
						state_d = S_PROG;
					end
					K_ON: begin
						if (stat.on_ok) begin
							cmd.tbl_rd = 1'b1;
							state_d = S_ON_READ;
						end
					end
					K_OFF: begin
						if (stat.off_ok) begin
							cmd.off_set = 1'b1;
							state_d = S_PROG;
						end
					end
					K_BEND: begin
						if (stat.bend_ok) begin
							cmd.tdiv_start = 1'b1;
							state_d = S_BEND_DIV;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ON_READ: begin
				cmd.on_set = 1'b1;
				state_d = S_PROG;
			end
			S_BEND_DIV: begin
				cmd.t_load = 1'b1;
				state_d = S_BEND_FAC;
			end
			S_BEND_FAC: begin
				cmd.fac_load   = 1'b1;
				cmd.first_busy = 1'b1;
				state_d = S_BEND_MUL;
			end
			S_BEND_MUL: begin
				cmd.bend_mul = 1'b1;
				state_d = S_BEND_SAT;
			end
			S_BEND_SAT: begin
				cmd.bend_sat = 1'b1;
				state_d = S_PROG;
			end
			S_PROG: begin
				cmd.prog_setup = 1'b1;
				state_d = S_PROG2;
			end
			S_PROG2: begin
				if (stat.zero) begin
					cmd.res_zero = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.rel_start = 1'b1;
					state_d = S_REL_WAIT;
				end
			end
			S_REL_WAIT: begin
				if (stat.div_done) begin
					cmd.res_rel = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!stat.out_full) begin
					if (stat.is_last) state_d = S_IDLE;
					else if (stat.kind == K_ALLOFF) begin
						cmd.alloff_next = 1'b1;
						state_d = S_PROG;
					end else begin
						cmd.next_busy = 1'b1;
						state_d = S_BEND_MUL;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/core/midi_voice_allocator_timer_setup.sv =====
// ----------------------------------------------------------------------------
// midi_voice_allocator_timer_setup
// Four-voice MIDI note allocator producing PWM timer settings per voice.
// Results: a note-on result follows its reload divide; a bend first computes
//   its factor, then gives one result per busy voice, each after its own
//   reload divide once the previous result is taken; disabled results skip it.
// Throughput: one item at a time; the results of an item come one at a time
//   through the shared bit-serial reload divider.
// Reset: arst_n clears voices, the sequencer and the output valid flag; the
//   config registers return to their defaults. The note table is not cleared.
// ----------------------------------------------------------------------------
module midi_voice_allocator_timer_setup #(
	parameter int TIMER_CLOCK_HZ = 64000000,
	parameter int NOTE_ENTRIES   = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // status, data1, data2, table_index, table_freq
	input  logic [1:0]  s_axis_tuser,  // req_type
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // voice, prescaler, reload, compare
	output logic        m_axis_tuser,  // enable
	output logic        m_axis_tlast,  // last result of an item
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mvat_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	logic [1:0]  voice;
	logic [9:0]  prescaler;
	logic [15:0] reload, compare;

	// sequencer: one item in flight, walks voices one result at a time
	mvat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: voice registers, note table memory, divider, result register
	mvat_dp #(
		.TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
		.NOTE_ENTRIES   (NOTE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (s_axis_tuser),
		.status      (s_axis_tdata[7:0]),
		.data1       (s_axis_tdata[14:8]),
		.data2       (s_axis_tdata[21:15]),
		.table_index (s_axis_tdata[28:22]),
		.table_freq  (s_axis_tdata[44:29]),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.voice       (voice),
		.enable      (m_axis_tuser),
		.prescaler   (prescaler),
		.reload      (reload),
		.compare     (compare),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, compare, reload, prescaler, voice};
endmodule
